// ----- hw/rtl/marl_pkg.sv -----
package marl_pkg;

  // Default number of table entries
  localparam int unsigned TableDepth = 32;

  // Field widths
  localparam int unsigned AddrW  = 64;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 6;

  // Operation codes carried in tuser
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_RESP
  } state_e;

  // Query token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic done;
    logic excl;
  } tok_t;

  // Broadcast write to the cell row
  typedef struct packed {
    logic             en;
    logic             merge;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] limit;
  } wr_t;

endpackage

// ----- hw/rtl/marl_cell.sv -----
module marl_cell #(
  parameter int unsigned DEPTH = marl_pkg::TableDepth,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CW-1:0]            total_i,
  input  logic [CW-1:0]            wr_idx_i,
  input  marl_pkg::wr_t            wr_i,
  input  logic [marl_pkg::AddrW-1:0] addr_i,
  input  marl_pkg::tok_t           tok_i,
  output marl_pkg::tok_t           tok_o
);

  logic [marl_pkg::AddrW-1:0] base_q;
  logic [marl_pkg::AddrW-1:0] limit_q;
  logic                       active;
  logic                       sel;
  marl_pkg::tok_t             tok_d;
  marl_pkg::tok_t             tok_q;

  assign active = (CW'(IDX) < total_i);
  assign sel    = wr_i.en && (wr_idx_i == CW'(IDX));

  // Entry storage: a merge only moves the limit
  always_ff @(posedge clk_i) begin
    if (sel) begin
      limit_q <= wr_i.limit;
      if (!wr_i.merge) begin
        base_q <= wr_i.base;
      end
    end
  end

  // Test the address against this entry, first hit wins
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done && active) begin
      if (addr_i < base_q) begin
        tok_d.done = 1'b1;
        tok_d.excl = 1'b0;
      end else if (addr_i < limit_q) begin
        tok_d.done = 1'b1;
        tok_d.excl = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- hw/rtl/merged_address_range_lookup.sv -----
// Channel  Dir  tdata                                   tuser
// s_axis   in   range_base, range_size, query_address    operation
// m_axis   out  excluded, entry_count, table_full        -
//
// One item at a time. Clear and append go through accept, execute and result.
// A query also walks the row: its token steps through one cell per cycle.
// Reset empties the table; entry contents are not cleared.
// A stalled result holds the block; the next item is taken after the transfer.
module merged_address_range_lookup #(
  parameter int unsigned DEPTH = marl_pkg::TableDepth,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [191:0] s_axis_tdata_i,  // range_base, range_size, query_address
  input  logic [1:0]   s_axis_tuser_i,  // operation
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o   // excluded, entry_count[5:0], table_full
);

  localparam int unsigned AW = marl_pkg::AddrW;

  marl_pkg::state_e state_q, state_d;
  marl_pkg::op_e    op_q;
  logic [AW-1:0]    base_q, size_q, addr_q, last_limit_q;
  logic [CW-1:0]    total_q, total_d;
  logic             res_excl_q, res_full_q;

  logic             merge, is_full, do_append, inject, capture;
  logic [AW-1:0]    new_limit;
  logic [CW-1:0]    wr_idx;
  marl_pkg::wr_t    wr;
  marl_pkg::tok_t   tok [DEPTH+1];
  logic [CW+5:0]    count_ext;

  // Append decode
  assign merge     = (total_q != '0) && (last_limit_q == base_q);
  assign is_full   = (total_q == CW'(DEPTH));
  assign new_limit = (merge ? last_limit_q : base_q) + size_q;
  assign wr_idx    = merge ? total_q - CW'(1) : total_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      marl_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = marl_pkg::ST_EXEC;
      marl_pkg::ST_EXEC: state_d = (op_q == marl_pkg::OP_QUERY) ? marl_pkg::ST_WALK
                                                                 : marl_pkg::ST_RESP;
      marl_pkg::ST_WALK: if (tok[DEPTH].valid) state_d = marl_pkg::ST_RESP;
      marl_pkg::ST_RESP: if (m_axis_tready_i) state_d = marl_pkg::ST_IDLE;
      default:           state_d = marl_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_axis_tready_o = (state_q == marl_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == marl_pkg::ST_RESP);
    do_append       = (state_q == marl_pkg::ST_EXEC) && (op_q == marl_pkg::OP_APPEND);
    inject          = (state_q == marl_pkg::ST_EXEC) && (op_q == marl_pkg::OP_QUERY);
    capture         = (state_q == marl_pkg::ST_WALK) && tok[DEPTH].valid;
    wr.en           = do_append && (merge || !is_full);
    wr.merge        = merge;
    wr.base         = base_q;
    wr.limit        = new_limit;
    total_d         = total_q;
    if ((state_q == marl_pkg::ST_EXEC) && (op_q == marl_pkg::OP_CLEAR)) begin
      total_d = '0;
    end else if (wr.en && !merge) begin
      total_d = total_q + CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= marl_pkg::ST_IDLE;
      total_q    <= '0;
      res_excl_q <= 1'b0;
      res_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == marl_pkg::ST_EXEC) begin
        res_excl_q <= 1'b0;
        res_full_q <= do_append && !merge && is_full;
      end
      if (capture) begin
        res_excl_q <= tok[DEPTH].excl;
      end
    end
  end

  // Item capture and tail limit
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q   <= marl_pkg::op_e'(s_axis_tuser_i);
      base_q <= s_axis_tdata_i[AW-1:0];
      size_q <= s_axis_tdata_i[2*AW-1:AW];
      addr_q <= s_axis_tdata_i[3*AW-1:2*AW];
    end
    if (wr.en) begin
      last_limit_q <= new_limit;
    end
  end

  // Row of cells, one entry each
  assign tok[0] = '{valid: inject, done: 1'b0, excl: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    marl_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .total_i  (total_q),
      .wr_idx_i (wr_idx),
      .wr_i     (wr),
      .addr_i   (addr_q),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  // Result word
  assign count_ext      = {6'b0, total_q};
  assign m_axis_tdata_o = {res_full_q, count_ext[marl_pkg::CountW-1:0], res_excl_q};

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output open together");

  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_full_q |-> is_full)
    else $error("dropped append while table not full");

  a_excl_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_excl_q |-> op_q == marl_pkg::OP_QUERY)
    else $error("excluded set on a non-query item");

  a_token_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[DEPTH].valid |-> state_q == marl_pkg::ST_WALK)
    else $error("token left the row outside a walk");
`endif

endmodule
